>>> design/msh_pkg.sv
// shared types, codes and helpers for the multi-stack handle engine
package msh_pkg;

  // operation codes carried on the kind field
  typedef enum logic [2:0] {
    KIND_ALLOC = 3'd0,
    KIND_FREE  = 3'd1,
    KIND_PUSH  = 3'd2,
    KIND_POP   = 3'd3,
    KIND_SIZE  = 3'd4,
    KIND_VALID = 3'd5
  } kind_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_NOFREE  = 3'd4
  } status_t;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned COUNT_W = 4;

  // keeps the low n bytes of a 64-bit word, n of eight or more keeps all
  function automatic logic [DATA_W-1:0] byte_mask(input logic [COUNT_W-1:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      if (COUNT_W'(b) < n) begin
        m[b*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

>>> design/msh_ram.sv
// generic single-write, single-read ram with registered read data
module msh_ram #(
  parameter int unsigned WIDTH = 68,
  parameter int unsigned DEPTH = 128
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds between reads
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/multi_stack_handle_engine_unit.sv
// top level of the multi-stack handle engine: handle bitmap, depths and element store
//
// The engine keeps MAX_STACKS independent LIFO stacks behind numbered handles.
// Each request is one operation: allocate (lowest unreserved handle), free,
// push, pop, size query or validity check, and each request yields exactly
// one result. The engine takes one request per cycle while in_ready is high.
// A result passes three registers. The first is the input register, where
// the handle bitmap and depth table are read and updated and the element
// store is written (push) or read (pop). The second holds the result fields
// while the element store does its registered read. The third is the output
// register. The whole pipe moves as one; when out_ready is low with a result
// waiting, in_ready drops in the same cycle and every stage holds.
// Back-to-back requests to the same stack need no forwarding because state
// and store are updated at the edge that moves the request out of the input
// register. The element store is one ram of MAX_STACKS*STACK_DEPTH words;
// it needs no clearing pass since only entries below a stack's depth are
// ever read.
module multi_stack_handle_engine_unit #(
  parameter int unsigned MAX_STACKS    = 8,
  parameter int unsigned STACK_DEPTH   = 16,
  parameter int unsigned ELEMENT_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [3:0]  in_handle,
  input  logic [63:0] in_data_value,
  input  logic [3:0]  in_byte_count,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [2:0]  out_handle_out,
  output logic [63:0] out_pop_value,
  output logic [3:0]  out_copied_bytes,
  output logic [4:0]  out_depth_out,
  output logic        out_handle_valid
);

  import msh_pkg::*;

  // handle index, depth counter, store address and element widths
  localparam int unsigned SW      = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int unsigned DW      = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ENTRIES = MAX_STACKS * STACK_DEPTH;
  localparam int unsigned AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned EW      = 8 * ELEMENT_BYTES;
  localparam int unsigned CW      = $clog2(ELEMENT_BYTES + 1);
  localparam int unsigned WW      = CW + EW;

  // pipe advance: every stage moves when the output register is empty or being read
  logic adv;

  // stage 1: input register
  logic              s1_vld_r;
  logic [2:0]        s1_kind_r;
  logic [3:0]        s1_handle_r;
  logic [DATA_W-1:0] s1_data_r;
  logic [3:0]        s1_count_r;

  // stage 2: result fields waiting for the store read
  logic          s2_vld_r;
  logic [2:0]    s2_status_r;
  logic [2:0]    s2_handle_out_r;
  logic          s2_pop_r;
  logic [3:0]    s2_req_r;
  logic [4:0]    s2_depth_r;
  logic          s2_hv_r;

  // output register
  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [2:0]        out_handle_out_r;
  logic [DATA_W-1:0] out_data_r;
  logic [3:0]        out_copied_r;
  logic [4:0]        out_depth_r;
  logic              out_hv_r;

  // stack state
  logic [MAX_STACKS-1:0] reserved_r, reserved_nxt;
  logic [DW-1:0]         depth_r   [MAX_STACKS];
  logic [DW-1:0]         depth_nxt [MAX_STACKS];

  // stage 1 decode
  logic [SW-1:0] h_idx;
  logic          h_in_range;
  logic          live;
  logic [DW-1:0] cur_depth;
  logic          free_found;
  logic [SW-1:0] free_idx;
  logic [3:0]    cnt_clamped;

  logic          push_ok, pop_ok;
  logic [2:0]    status;
  logic [SW-1:0] granted;
  logic          rep_live;
  logic [DW-1:0] rep_depth;
  logic [DW-1:0] offset;
  logic [AW-1:0] mem_addr;
  logic [WW-1:0] mem_wdata;
  logic [WW-1:0] mem_rdata;
  logic          mem_we, mem_re;

  // pop result path
  logic [3:0]        have_bytes;
  logic [3:0]        pop_n;
  logic [DATA_W-1:0] pop_data;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  assign h_idx      = SW'(s1_handle_r);
  assign h_in_range = 32'(s1_handle_r) < 32'(MAX_STACKS);
  assign live       = h_in_range && reserved_r[h_idx];
  assign cur_depth  = depth_r[h_idx];

  // saturate oversized byte counts
  assign cnt_clamped = (s1_count_r > 4'(ELEMENT_BYTES)) ? 4'(ELEMENT_BYTES) : s1_count_r;

  // lowest unreserved handle
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_STACKS - 1; i >= 0; i--) begin
      if (!reserved_r[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // operation decode and result fields
  always_comb begin
    status    = ST_OK;
    granted   = '0;
    push_ok   = 1'b0;
    pop_ok    = 1'b0;
    rep_live  = live;
    rep_depth = live ? cur_depth : '0;
    offset    = cur_depth;
    case (s1_kind_r)
      KIND_ALLOC: begin
        if (free_found) begin
          granted   = free_idx;
          rep_live  = 1'b1;
          rep_depth = '0;
        end else begin
          status    = ST_NOFREE;
          rep_live  = 1'b0;
          rep_depth = '0;
        end
      end
      KIND_FREE: begin
        if (!live) begin
          status = ST_INVALID;
        end
        rep_live  = 1'b0;
        rep_depth = '0;
      end
      KIND_PUSH: begin
        if (!live) begin
          status = ST_INVALID;
        end else if (32'(cur_depth) >= 32'(STACK_DEPTH)) begin
          status = ST_FULL;
        end else begin
          push_ok   = 1'b1;
          rep_depth = cur_depth + 1'b1;
        end
      end
      KIND_POP: begin
        offset = cur_depth - 1'b1;
        if (!live) begin
          status = ST_INVALID;
        end else if (cur_depth == '0) begin
          status = ST_EMPTY;
        end else begin
          pop_ok    = 1'b1;
          rep_depth = cur_depth - 1'b1;
        end
      end
      KIND_SIZE, KIND_VALID: begin
        if (!live) begin
          status = ST_INVALID;
        end
      end
      default: begin
        // unused kinds only report the addressed handle
      end
    endcase
  end

  // next stack state
  always_comb begin
    reserved_nxt = reserved_r;
    depth_nxt    = depth_r;
    case (s1_kind_r)
      KIND_ALLOC: begin
        if (free_found) begin
          reserved_nxt[free_idx] = 1'b1;
          depth_nxt[free_idx]    = '0;
        end
      end
      KIND_FREE: begin
        if (live) begin
          reserved_nxt[h_idx] = 1'b0;
          depth_nxt[h_idx]    = '0;
        end
      end
      KIND_PUSH: begin
        if (push_ok) begin
          depth_nxt[h_idx] = cur_depth + 1'b1;
        end
      end
      KIND_POP: begin
        if (pop_ok) begin
          depth_nxt[h_idx] = cur_depth - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // element store: stack base plus top offset
  assign mem_addr  = AW'(int'(h_idx) * int'(STACK_DEPTH) + int'(offset));
  assign mem_wdata = {CW'(cnt_clamped), EW'(s1_data_r & byte_mask(cnt_clamped))};
  assign mem_we    = adv && s1_vld_r && push_ok;
  assign mem_re    = adv && s1_vld_r && pop_ok;

  msh_ram #(
    .WIDTH (WW),
    .DEPTH (ENTRIES)
  ) u_elem_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  // popped bytes limited to min(stored, requested)
  assign have_bytes = 4'(mem_rdata[WW-1 -: CW]);
  assign pop_n      = (have_bytes < s2_req_r) ? have_bytes : s2_req_r;
  assign pop_data   = DATA_W'(mem_rdata[EW-1:0]) & byte_mask(pop_n);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      reserved_r  <= '0;
      for (int i = 0; i < MAX_STACKS; i++) begin
        depth_r[i] <= '0;
      end
    end else if (adv) begin
      s1_vld_r    <= in_valid;
      s2_vld_r    <= s1_vld_r;
      out_valid_r <= s2_vld_r;
      if (s1_vld_r) begin
        reserved_r <= reserved_nxt;
        depth_r    <= depth_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      if (in_valid) begin
        s1_kind_r   <= in_kind;
        s1_handle_r <= in_handle;
        s1_data_r   <= in_data_value;
        s1_count_r  <= in_byte_count;
      end
      s2_status_r     <= status;
      s2_handle_out_r <= 3'(granted);
      s2_pop_r        <= pop_ok;
      s2_req_r        <= cnt_clamped;
      s2_depth_r      <= 5'(rep_depth);
      s2_hv_r         <= rep_live;
      out_status_r     <= s2_status_r;
      out_handle_out_r <= s2_handle_out_r;
      out_data_r       <= s2_pop_r ? pop_data : '0;
      out_copied_r     <= s2_pop_r ? pop_n : 4'd0;
      out_depth_r      <= s2_depth_r;
      out_hv_r         <= s2_hv_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_handle_out   = out_handle_out_r;
  assign out_pop_value    = out_data_r;
  assign out_copied_bytes = out_copied_r;
  assign out_depth_out    = out_depth_r;
  assign out_handle_valid = out_hv_r;

endmodule

>>> tb/sv/tb_multi_stack_handle_engine_unit.sv
// self-checking testbench for the multi-stack handle engine
`timescale 1ns / 1ps

module tb_multi_stack_handle_engine_unit;
  import msh_pkg::*;

  // sizes of the instance under test
  localparam int unsigned MAX_HANDLES = 8;
  localparam int unsigned STACK_SLOTS = 16;
  localparam int unsigned ELEM_BYTES  = 8;

  // kind codes the package leaves unnamed, answered as no-ops
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  localparam int unsigned RANDOM_REQUESTS = 1700;
  localparam int unsigned HOLD_CYCLES     = 150;
  localparam int unsigned DRAIN_CYCLES    = 12;
  localparam int unsigned MAX_PRINTED     = 40;

  // one request as offered on the input channel
  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  handle;
    logic [63:0] value;
    logic [3:0]  count;
  } stack_request_t;

  // one result as expected on the output channel
  typedef struct {
    status_t     status;
    logic [2:0]  granted;
    logic [63:0] data;
    logic [3:0]  copied;
    logic [4:0]  depth;
    logic        live;
  } stack_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_kind;
  logic [3:0]  in_handle;
  logic [63:0] in_data_value;
  logic [3:0]  in_byte_count;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [2:0]  out_handle_out;
  logic [63:0] out_pop_value;
  logic [3:0]  out_copied_bytes;
  logic [4:0]  out_depth_out;
  logic        out_handle_valid;

  // requests waiting to be offered, results waiting to arrive
  stack_request_t pending_requests[$];
  stack_result_t  expected_results[$];

  int unsigned total_requests = 0;
  int unsigned accepted_count = 0;
  int unsigned result_count   = 0;
  int unsigned error_count    = 0;
  logic        hold_off;

  // shadow copy of the handle bitmap, depths and element store
  bit          slot_live [MAX_HANDLES];
  int unsigned slot_depth[MAX_HANDLES];
  logic [63:0] slot_value[MAX_HANDLES][STACK_SLOTS];
  logic [3:0]  slot_bytes[MAX_HANDLES][STACK_SLOTS];

  multi_stack_handle_engine_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_handle        (in_handle),
    .in_data_value    (in_data_value),
    .in_byte_count    (in_byte_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_handle_out   (out_handle_out),
    .out_pop_value    (out_pop_value),
    .out_copied_bytes (out_copied_bytes),
    .out_depth_out    (out_depth_out),
    .out_handle_valid (out_handle_valid)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------
  // stack model
  // ---------------------------------------------------------------

  function automatic bit handle_live(input int unsigned h);
    if (h >= MAX_HANDLES) return 1'b0;
    return slot_live[h];
  endfunction

  // counts above the element width saturate
  function automatic int unsigned clamp_bytes(input logic [3:0] count);
    return (count > ELEM_BYTES) ? ELEM_BYTES : int'(count);
  endfunction

  // low n bytes set
  function automatic logic [63:0] keep_bytes(input int unsigned n);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  // applies one request to the shadow state and returns its result
  function automatic stack_result_t apply_stack_op(input logic [2:0] kind,
                                                   input logic [3:0] h,
                                                   input logic [63:0] value,
                                                   input logic [3:0] count);
    stack_result_t r;
    int unsigned   report;
    int unsigned   n;
    int unsigned   have;
    int unsigned   top;
    r.status  = ST_OK;
    r.granted = '0;
    r.data    = '0;
    r.copied  = '0;
    r.depth   = '0;
    r.live    = 1'b0;
    report    = h;
    case (kind)
      KIND_ALLOC: begin
        // downward scan leaves the lowest free handle
        report = MAX_HANDLES;
        for (int i = MAX_HANDLES - 1; i >= 0; i--) begin
          if (!slot_live[i]) report = i;
        end
        if (report < MAX_HANDLES) begin
          slot_live[report]  = 1'b1;
          slot_depth[report] = 0;
          r.granted          = 3'(report);
        end else begin
          r.status = ST_NOFREE;
        end
      end
      KIND_FREE: begin
        if (!handle_live(h)) begin
          r.status = ST_INVALID;
        end else begin
          slot_live[h]  = 1'b0;
          slot_depth[h] = 0;
        end
      end
      KIND_PUSH: begin
        if (!handle_live(h)) begin
          r.status = ST_INVALID;
        end else if (slot_depth[h] >= STACK_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          n                           = clamp_bytes(count);
          slot_value[h][slot_depth[h]] = value & keep_bytes(n);
          slot_bytes[h][slot_depth[h]] = 4'(n);
          slot_depth[h]++;
        end
      end
      KIND_POP: begin
        if (!handle_live(h)) begin
          r.status = ST_INVALID;
        end else if (slot_depth[h] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          top      = slot_depth[h] - 1;
          have     = slot_bytes[h][top];
          n        = (have < clamp_bytes(count)) ? have : clamp_bytes(count);
          r.data   = slot_value[h][top] & keep_bytes(n);
          r.copied = 4'(n);
          slot_depth[h]--;
        end
      end
      KIND_SIZE, KIND_VALID: begin
        if (!handle_live(h)) r.status = ST_INVALID;
      end
      default: ;
    endcase
    if (handle_live(report)) begin
      r.depth = 5'(slot_depth[report]);
      r.live  = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------

  task automatic queue_request(input logic [2:0] kind, input logic [3:0] h,
                               input logic [63:0] value, input logic [3:0] count);
    stack_request_t req;
    req.kind   = kind;
    req.handle = h;
    req.value  = value;
    req.count  = count;
    pending_requests.push_back(req);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // mostly legal byte counts, now and then an oversized one
  function automatic logic [3:0] rand_count();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(9, 15));
    return 4'($urandom_range(0, 8));
  endfunction

  function automatic logic [3:0] rand_live_handle();
    return 4'($urandom_range(0, MAX_HANDLES - 1));
  endfunction

  // idle rates by phase: receiver-heavy, then swapped to sender-heavy, then none
  function automatic int unsigned sender_idle_pct();
    if (accepted_count < total_requests / 3) return 38;
    if (accepted_count < 2 * total_requests / 3) return 68;
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct();
    if (accepted_count < total_requests / 3) return 68;
    if (accepted_count < 2 * total_requests / 3) return 38;
    return 0;
  endfunction

  task automatic build_directed();
    // operations on a handle nobody reserved, out-of-range handle, spare kinds
    queue_request(KIND_POP, 4'd0, rand_word(), 4'd8);
    queue_request(KIND_SIZE, 4'd15, rand_word(), 4'd0);
    queue_request(KIND_SPARE6, 4'd0, '1, 4'd15);
    queue_request(KIND_SPARE7, 4'd9, '0, 4'd0);
    // first grant, then pop on an empty stack
    queue_request(KIND_ALLOC, 4'd7, rand_word(), rand_count());
    queue_request(KIND_POP, 4'd0, rand_word(), 4'd8);
    // full-width, zero-byte, oversized and partial pushes
    queue_request(KIND_PUSH, 4'd0, '1, 4'd8);
    queue_request(KIND_PUSH, 4'd0, 64'h0123_4567_89ab_cdef, 4'd0);
    queue_request(KIND_PUSH, 4'd0, 64'hfedc_ba98_7654_3210, 4'd15);
    queue_request(KIND_PUSH, 4'd0, rand_word(), 4'd3);
    // pops with oversized, short and zero-byte outcomes
    queue_request(KIND_POP, 4'd0, '1, 4'd15);
    queue_request(KIND_POP, 4'd0, '1, 4'd2);
    queue_request(KIND_POP, 4'd0, '0, 4'd8);
    queue_request(KIND_SIZE, 4'd0, '0, 4'd0);
    queue_request(KIND_VALID, 4'd0, '0, 4'd0);
    // grant every remaining handle, then one more with none left
    repeat (MAX_HANDLES) queue_request(KIND_ALLOC, 4'($urandom_range(0, 15)),
                                       rand_word(), rand_count());
    // release, then stale and out-of-range releases
    queue_request(KIND_FREE, 4'd3, '0, 4'd0);
    queue_request(KIND_VALID, 4'd3, '0, 4'd0);
    queue_request(KIND_FREE, 4'd3, '0, 4'd0);
    queue_request(KIND_FREE, 4'd12, '0, 4'd0);
  endtask

  task automatic build_random();
    int unsigned stop_at;
    int unsigned sel;
    logic [3:0]  h;
    stop_at = pending_requests.size() + RANDOM_REQUESTS;
    while (pending_requests.size() < stop_at) begin
      sel = $urandom_range(0, 99);
      h   = rand_live_handle();
      if (sel < 50) begin
        // push burst then pop burst on one stack, long enough to fill or drain
        repeat ($urandom_range(1, 20)) begin
          if ($urandom_range(0, 9) == 0)
            queue_request(KIND_SIZE, h, rand_word(), rand_count());
          queue_request(KIND_PUSH, h, rand_word(), rand_count());
        end
        repeat ($urandom_range(1, 20)) queue_request(KIND_POP, h, rand_word(), rand_count());
      end else if (sel < 65) begin
        repeat ($urandom_range(1, 3))
          queue_request(KIND_ALLOC, 4'($urandom), rand_word(), rand_count());
      end else if (sel < 75) begin
        queue_request(KIND_FREE, h, rand_word(), rand_count());
        if ($urandom_range(0, 1) == 0) queue_request(KIND_VALID, h, rand_word(), rand_count());
      end else if (sel < 80) begin
        // run the handle pool dry
        repeat (MAX_HANDLES + 1)
          queue_request(KIND_ALLOC, 4'($urandom), rand_word(), rand_count());
      end else begin
        // noise: any kind, any handle, any count
        repeat ($urandom_range(1, 6))
          queue_request(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                        rand_word(), 4'($urandom_range(0, 15)));
      end
    end
  endtask

  // ---------------------------------------------------------------
  // driver: offers queued requests, predicts each accepted one
  // ---------------------------------------------------------------

  always @(posedge clk) begin : request_driver
    stack_request_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      // request on the bus was taken at this edge
      if (in_valid) begin
        expected_results.push_back(apply_stack_op(in_kind, in_handle, in_data_value,
                                                  in_byte_count));
        accepted_count++;
      end
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
        req = pending_requests.pop_front();
        in_valid      <= 1'b1;
        in_kind       <= req.kind;
        in_handle     <= req.handle;
        in_data_value <= req.value;
        in_byte_count <= req.count;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // monitor: checks results in order, throttles out_ready
  // ---------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < MAX_PRINTED)
      $display("[%0t] result %0d: %s got 0x%0h expected 0x%0h",
               $realtime, result_count, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : result_monitor
    stack_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", out_status, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_handle_out !== want.granted)
            report_mismatch("handle_out", out_handle_out, want.granted);
          if (out_pop_value !== want.data)
            report_mismatch("pop_value", out_pop_value, want.data);
          if (out_copied_bytes !== want.copied)
            report_mismatch("copied_bytes", out_copied_bytes, want.copied);
          if (out_depth_out !== want.depth)
            report_mismatch("depth_out", out_depth_out, want.depth);
          if (out_handle_valid !== want.live)
            report_mismatch("handle_valid", out_handle_valid, want.live);
        end
        result_count++;
      end
      out_ready <= hold_off ? 1'b0 : ($urandom_range(0, 99) >= receiver_idle_pct());
    end
  end

  // long receiver stall in the no-idle phase so the pipe backs up into in_ready
  initial begin : receiver_hold_off
    int unsigned cycles;
    hold_off = 1'b0;
    @(posedge clk);
    while (!rst_n || accepted_count < 2 * total_requests / 3 + 40) @(posedge clk);
    hold_off <= 1'b1;
    for (cycles = 0; cycles < HOLD_CYCLES; cycles++) @(posedge clk);
    hold_off <= 1'b0;
  end

  // run limit, far beyond the slowest legal run
  initial begin : run_limit
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------
  // main sequence: build stimulus, reset, drain, verdict
  // ---------------------------------------------------------------

  initial begin : main_sequence
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = '0;
    in_handle     = '0;
    in_data_value = '0;
    in_byte_count = '0;
    out_ready     = 1'b0;
    build_directed();
    build_random();
    total_requests = pending_requests.size();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // every request taken and every result back
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    // catch any stray result behind the last one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
